// ===== design/via_pkg.sv =====
// ----------------------------------------------------------------------------
// via_pkg
// Opcodes, error codes and shared types of the integer ALU.
// ----------------------------------------------------------------------------
package via_pkg;

    typedef enum logic [4:0] {
        OP_EQ   = 5'd0,
        OP_NE   = 5'd1,
        OP_LT   = 5'd2,
        OP_LE   = 5'd3,
        OP_LNOT = 5'd4,
        OP_NEG  = 5'd5,
        OP_ADD  = 5'd6,
        OP_SUB  = 5'd7,
        OP_MUL  = 5'd8,
        OP_BNOT = 5'd9,
        OP_AND  = 5'd10,
        OP_OR   = 5'd11,
        OP_XOR  = 5'd12,
        OP_SHL  = 5'd13,
        OP_SHR  = 5'd14,
        OP_DIV  = 5'd15,
        OP_MOD  = 5'd16
    } opcode_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_DIV0  = 2'd1,
        ERR_SHIFT = 2'd2
    } err_t;

    localparam int unsigned FIELD_WIDTH = 64;
    localparam int unsigned OPCODE_WIDTH = 5;
    localparam int unsigned ERR_WIDTH = 2;

endpackage

// ===== design/via_if.sv =====
// ----------------------------------------------------------------------------
// via_in_if / via_out_if
// Valid/ready channels carrying instruction and result beats.
// ----------------------------------------------------------------------------
interface via_in_if;
    import via_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [OPCODE_WIDTH-1:0] opcode;
    logic [FIELD_WIDTH-1:0]  operand_b;
    logic [FIELD_WIDTH-1:0]  operand_c;
    modport source (output valid, opcode, operand_b, operand_c, input ready);
    modport sink   (input valid, opcode, operand_b, operand_c, output ready);
endinterface

interface via_out_if;
    import via_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] result;
    logic [ERR_WIDTH-1:0]   error_code;
    modport source (output valid, result, error_code, input ready);
    modport sink   (input valid, result, error_code, output ready);
endinterface

// ===== design/via_div_stage.sv =====
// ----------------------------------------------------------------------------
// via_div_stage
// One registered restoring-division step group (STEPS quotient bits).
// ----------------------------------------------------------------------------
module via_div_stage #(
    parameter int W     = 64,
    parameter int STEPS = 8
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] rem_in,
    input  logic [W-1:0] quo_in,
    input  logic [W-1:0] den_in,
    output logic [W-1:0] rem_reg,
    output logic [W-1:0] quo_reg
);
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;
    logic [W:0]   trial;
    logic         bit_in;

    always_comb
    begin
        rem_next = rem_in;
        quo_next = quo_in;
        trial    = '0;
        bit_in   = 1'b0;
        for (int i = 0; i < STEPS; i++)
        begin
            // next dividend bit comes off the top of the quotient register
            bit_in   = quo_next[W-1];
            trial    = {rem_next, bit_in} - {1'b0, den_in};
            quo_next = {quo_next[W-2:0], ~trial[W]};
            if (!trial[W])
                rem_next = trial[W-1:0];
            else
                rem_next = {rem_next[W-2:0], bit_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end
endmodule

// ===== design/vm_integer_alu_core.sv =====
// ----------------------------------------------------------------------------
// vm_integer_alu_core
// Throughput: one beat per cycle; the pipeline advances when the output
// register is empty or being taken, so a stall freezes every stage in place.
// Depth is set by the divider, up to eight quotient bits per stage.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module vm_integer_alu_core #(
    parameter int WORD_WIDTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    via_in_if.sink    in_ch,
    via_out_if.source out_ch
);
    import via_pkg::*;

    localparam int W      = WORD_WIDTH;
    localparam int NDIV   = (W + 7) / 8;
    localparam int NST    = NDIV + 3;   // s0 decode, NDIV div, fix, out
    localparam int SHW    = $clog2(W);

    typedef struct packed {
        logic [4:0]   op;
        logic [W-1:0] res;      // finished result for all but mul, div and mod
        logic [1:0]   err;
        logic         negq;
        logic         negr;
        logic         force0;
    } ctl_t;

    // Pipeline advance: whole pipe moves together.
    logic adv;
    logic [NST-1:0] vld_reg;
    assign adv = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    // ---------------- stage 0: decode, simple ops, multiply, operands ----
    logic [W-1:0] b, c, ub, uc, mag_b, mag_c, sh_out;
    logic [SHW-1:0] sh;
    logic signed [W-1:0] sb, sc;
    ctl_t ctl0;
    assign b  = in_ch.operand_b[W-1:0];
    assign c  = in_ch.operand_c[W-1:0];
    assign sb = b;
    assign sc = c;
    assign mag_b = b[W-1] ? (~b + 1'b1) : b;
    assign mag_c = c[W-1] ? (~c + 1'b1) : c;
    // count clamps to W-1 when a bit above the index, sign bit apart, is set
    assign sh = (|c[W-2:SHW]) ? SHW'(W-1)
              : ((c[SHW-1:0] > SHW'(W-1)) ? SHW'(W-1) : c[SHW-1:0]);
    assign sh_out = (in_ch.opcode == OP_SHL) ? (b << sh) : W'(sb >>> sh);

    always_comb
    begin
        ctl0 = '0;
        ctl0.op = in_ch.opcode;
        unique case (in_ch.opcode)
            OP_EQ:   ctl0.res = W'(b == c);
            OP_NE:   ctl0.res = W'(b != c);
            OP_LT:   ctl0.res = W'(sb < sc);
            OP_LE:   ctl0.res = W'(sb <= sc);
            OP_LNOT: ctl0.res = W'(b == '0);
            OP_NEG:  ctl0.res = '0 - b;
            OP_ADD:  ctl0.res = b + c;
            OP_SUB:  ctl0.res = b - c;
            OP_BNOT: ctl0.res = ~b;
            OP_AND:  ctl0.res = b & c;
            OP_OR:   ctl0.res = b | c;
            OP_XOR:  ctl0.res = b ^ c;
            OP_SHL, OP_SHR:
            begin
                if (c[W-1]) ctl0.err = ERR_SHIFT;
                else        ctl0.res = sh_out;
            end
            OP_DIV, OP_MOD:
            begin
                if (c == '0) ctl0.err = ERR_DIV0;
                ctl0.force0 = (c == '0) ||
                    (b == {1'b1, {(W-1){1'b0}}} && c == {W{1'b1}});
                ctl0.negq = b[W-1] ^ c[W-1];
                ctl0.negr = b[W-1];
            end
            default: ctl0.res = '0;
        endcase
    end
    assign ub = mag_b;
    assign uc = mag_c;

    // Multiply split into partial products: low-half terms registered here.
    // Lower half rounded up so the high-by-high term always falls off the word.
    localparam int H = (W + 1) / 2;
    logic [W-1:0] pll_reg, plh_reg, phl_reg;

    // Control and operand delay lines
    ctl_t         ctl_reg [NDIV+1];
    logic [W-1:0] den_reg [NDIV];
    logic [W-1:0] rem_w   [NDIV+1];
    logic [W-1:0] quo_w   [NDIV+1];
    logic [W-1:0] mul_reg [1:NDIV];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], in_ch.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= ctl0;
            den_reg[0] <= uc;
            pll_reg    <= W'(b[H-1:0]) * W'(c[H-1:0]);
            plh_reg    <= W'(b[H-1:0]) * W'(c[W-1:H]);
            phl_reg    <= W'(b[W-1:H]) * W'(c[H-1:0]);
            for (int i = 1; i <= NDIV; i++)
                ctl_reg[i] <= ctl_reg[i-1];
            for (int i = 1; i < NDIV; i++)
                den_reg[i] <= den_reg[i-1];
            mul_reg[1] <= pll_reg + ((plh_reg + phl_reg) << H);
            for (int i = 2; i <= NDIV; i++)
                mul_reg[i] <= mul_reg[i-1];
        end
    end

    // dividend enters as the quotient shift register, remainder starts at 0
    logic [W-1:0] ub_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            ub_reg <= ub;
    end
    assign rem_w[0] = '0;
    assign quo_w[0] = ub_reg;

    genvar g;
    generate
        for (g = 0; g < NDIV; g++)
        begin : g_div
            localparam int ST = (g == NDIV - 1) ? (W - 8 * (NDIV - 1)) : 8;
            via_div_stage #(.W(W), .STEPS(ST)) u_stage (
                .clk    (clk),
                .en     (adv),
                .rem_in (rem_w[g]),
                .quo_in (quo_w[g]),
                .den_in (den_reg[g]),
                .rem_reg(rem_w[g+1]),
                .quo_reg(quo_w[g+1])
            );
        end
    endgenerate

    // ---------------- fix-up stage and output register --------------------
    ctl_t         cf;
    logic [W-1:0] fix_next, fix_reg, res_reg;
    logic [1:0]   err_fix_reg, err_reg;
    assign cf = ctl_reg[NDIV];

    always_comb
    begin
        unique case (cf.op)
            OP_MUL:  fix_next = mul_reg[NDIV];
            OP_DIV:  fix_next = cf.force0 ? '0
                     : (cf.negq ? '0 - quo_w[NDIV] : quo_w[NDIV]);
            OP_MOD:  fix_next = cf.force0 ? '0
                     : (cf.negr ? '0 - rem_w[NDIV] : rem_w[NDIV]);
            default: fix_next = cf.res;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fix_reg     <= fix_next;
            err_fix_reg <= cf.err;
            res_reg     <= fix_reg;
            err_reg     <= err_fix_reg;
        end
    end

    assign out_ch.valid      = vld_reg[NST-1];
    assign out_ch.result     = FIELD_WIDTH'(signed'(res_reg));
    assign out_ch.error_code = err_reg;

    // ---------------- assertions ------------------------------------------
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && err_reg != ERR_NONE |-> res_reg == '0)
        else $error("non-zero result with error");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("pipe stalled while output empty");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_reg))
        else $error("stalled result lost");
endmodule
